// ----- hw/rtl/tmes_pkg.sv -----
// Shared constants and types for the tail mean (expected shortfall) block.
`default_nettype none
package tmes_pkg;
  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned DataW      = 32;
  localparam int unsigned LevelW     = 16;
  localparam logic [LevelW-1:0] LevelReset = 16'd3277;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_OVF   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUT,
    ST_PIV_RD,
    ST_PIV_LD,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ----- hw/rtl/tmes_store.sv -----
// Sample memory with one write port and one read port; read data is registered.
`default_nettype none
module tmes_store
  import tmes_pkg::*;
#(
  parameter int unsigned Depth = MaxSamples,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tmes_div.sv -----
// Bit-serial restoring divider: signed dividend by unsigned divisor, truncated.
`default_nettype none
module tmes_div
  import tmes_pkg::*;
#(
  parameter int unsigned NumW = 43,
  parameter int unsigned DenW = 11,
  localparam int unsigned IW  = $clog2(NumW + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quot_o
);
  logic            run_q, neg_q, done_q;
  logic [IW-1:0]   cnt_q;
  logic [NumW-1:0] q_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW+1:0] shifted;

  assign shifted = {rem_q, q_q[NumW-1]};
  assign trial   = shifted[DenW:0] - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= IW'(NumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == IW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      neg_q <= num_i[NumW-1];
      q_q   <= num_i[NumW-1] ? (~num_i + 1'b1) : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      if (!shifted[DenW+1] && !trial[DenW]) begin
        rem_q <= trial;
        q_q   <= {q_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DenW:0] - (shifted[DenW+1] ? {1'b0, den_q} : '0);
        q_q   <= {q_q[NumW-2:0], shifted[DenW+1]};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;
endmodule
`default_nettype wire

// ----- hw/rtl/tail_mean_expected_shortfall.sv -----
// Top level: sample capture, rank-based tail selection and mean sequencer.
// Samples are accepted while busy is low; after the last sample each kept sample's rank is
// found by one full sweep of the single memory read port, then a divide gives the mean. An
// empty tail goes straight to the result.
// Throughput: one batch at a time; busy is high from the last sample until the result.
// Reset: asynchronous, active low; clears the sample counter and overflow flag, sets level to 3277.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
module tail_mean_expected_shortfall
  import tmes_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MaxSamples,
  localparam int unsigned AW = $clog2(MAX_SAMPLES),
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SW = DataW + CW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DataW-1:0]  loss_sample_i,
  input  wire logic              last_sample_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [LevelW-1:0] cfg_data_i,
  output logic                   result_valid_o,
  output logic [DataW-1:0]       tail_mean_o,
  output logic [CW-1:0]          tail_count_o,
  output logic [1:0]             status_o
);
  state_e state_q, state_d;
  logic [LevelW-1:0] level_q;
  logic [CW-1:0]     cnt_q, n_q, tail_q, i_q, j_q, rank_q;
  logic              ovf_q, cmp_vld_q;
  logic [AW-1:0]     cmp_idx_q, raddr;
  logic [DataW-1:0]  pivot_q, rdata;
  logic [SW-1:0]     sum_q, quot;
  logic [DataW-1:0]  mean_q;
  logic              div_done, accept, full, greater;
  logic [LevelW+CW:0] prod;

  assign accept = start && !busy;
  assign full   = (cnt_q == CW'(MAX_SAMPLES));
  assign prod   = (LevelW+CW+1)'((17'h10000 - {1'b0, level_q}) * n_q);
  assign greater = ($signed(rdata) > $signed(pivot_q)) ||
                   ((rdata == pivot_q) && (CW'(cmp_idx_q) > i_q));

  tmes_store #(.Depth(MAX_SAMPLES)) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && !full),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (loss_sample_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tmes_div #(.NumW(SW), .DenW(CW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (state_q == ST_DIV_GO),
    .num_i  (sum_q),
    .den_i  (tail_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept && last_sample_i) state_d = ST_CUT;
      ST_CUT:      state_d = (n_q == CW'(prod[LevelW+CW:LevelW])) ? ST_OUT : ST_PIV_RD;
      ST_PIV_RD:   state_d = ST_PIV_LD;
      ST_PIV_LD:   state_d = ST_SCAN;
      ST_SCAN:     if (j_q == n_q && !cmp_vld_q) state_d = ST_DECIDE;
      ST_DECIDE:   state_d = (i_q + 1'b1 == n_q) ? ST_DIV_GO : ST_PIV_RD;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ST_OUT;
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_q != ST_IDLE);
    cfg_ready_o    = (state_q == ST_IDLE);
    result_valid_o = (state_q == ST_OUT);
    raddr          = (state_q == ST_PIV_RD) ? i_q[AW-1:0] : j_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      level_q   <= LevelReset;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) level_q <= cfg_data_i;
      if (accept) begin
        if (full) ovf_q <= 1'b1;
        else      cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_OUT) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      cmp_vld_q <= (state_q == ST_SCAN) && (j_q != n_q);
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= j_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        n_q <= full ? cnt_q : cnt_q + 1'b1;
      end
      ST_CUT: begin
        tail_q <= n_q - CW'(prod[LevelW+CW:LevelW]);
        i_q    <= '0;
        sum_q  <= '0;
        mean_q <= '0;
      end
      ST_PIV_LD: begin
        pivot_q <= rdata;
        j_q     <= '0;
        rank_q  <= '0;
      end
      ST_SCAN: begin
        if (j_q != n_q) j_q <= j_q + 1'b1;
        if (cmp_vld_q && greater) rank_q <= rank_q + 1'b1;
      end
      ST_DECIDE: begin
        if (rank_q < tail_q) sum_q <= sum_q + SW'($signed(pivot_q));
        i_q <= i_q + 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_done) mean_q <= quot[DataW-1:0];
      end
      default: ;
    endcase
  end

  assign tail_mean_o  = mean_q;
  assign tail_count_o = tail_q;
  assign status_o     = ovf_q ? STATUS_OVF : ((tail_q == '0) ? STATUS_EMPTY : STATUS_OK);
endmodule
`default_nettype wire

// ----- hw/rtl/tmes_checker.sv -----
// Port-level checker for the tail mean block, bound to the top level.
`default_nettype none
module tmes_checker
  import tmes_pkg::*;
#(
  parameter int unsigned CW = 11
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             last_sample_i,
  input wire logic             result_valid_o,
  input wire logic [DataW-1:0] tail_mean_o,
  input wire logic [CW-1:0]    tail_count_o,
  input wire logic [1:0]       status_o
);
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy) else $error("result not single");
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_sample_i |=> busy) else $error("last transfer did not start work");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == STATUS_EMPTY |-> tail_count_o == '0 && tail_mean_o == '0)
    else $error("empty tail not zero");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o != 2'd3) else $error("bad status");
endmodule

bind tail_mean_expected_shortfall tmes_checker #(.CW(CW)) u_tmes_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .last_sample_i  (last_sample_i),
  .result_valid_o (result_valid_o),
  .tail_mean_o    (tail_mean_o),
  .tail_count_o   (tail_count_o),
  .status_o       (status_o)
);
`default_nettype wire
